[rtl/gaic_pkg.sv]
// shared types and constants of the gyro angle integrator
package gaic_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 24;
   localparam int LEN_W      = 8;
   localparam int ANGLE_W    = 32;
   localparam int TOTAL_W    = 24;
   localparam int DIV_W      = 25;
   localparam int DSR_W      = 8;
   localparam int CMDQ_DEPTH = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 30;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_ABORT  = 2'd2;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_ABORT  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_TURN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAB_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_COUNT   = 2'd2;

   localparam logic [29:0] HALF_TURN_RST  = 30'd147456;
   localparam logic [15:0] STAB_LIMIT_RST = 16'd125;
   localparam logic [7:0]  CAL_COUNT_RST  = 8'd250;

   localparam logic signed [SAMPLE_W-1:0] CAL_HIGH_RST = -16'sd32768;
   localparam logic signed [SAMPLE_W-1:0] CAL_LOW_RST  = 16'sd32767;

   typedef struct packed {
      logic [1:0]                 mode;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_of_batch;
   } req_type;

   typedef struct packed {
      logic signed [30:0]         angle;
      logic signed [SAMPLE_W-1:0] rate;
      logic                       new_data;
      logic                       calibrating;
      logic                       calibration_done;
      logic signed [SAMPLE_W-1:0] zero_offset;
   } rsp_type;

   typedef struct packed {
      logic [29:0] half_turn;
      logic [15:0] stability_limit;
      logic [7:0]  calibration_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

[rtl/gyro_angle_integrator_with_calibration_top.sv]
// top level of the gyro angle integrator with zero offset calibration
// Each beat on req_ gives exactly one result beat on rsp_. A beat that ends
// no batch passes from the command queue through the emit state into the
// result register; a beat that ends a batch first waits for the 25-step
// serial divider that forms the batch mean, and a batch end that finishes
// calibration then waits for the same divider again, since it then forms the
// rounded offset. A two-entry command queue takes new beats while
// the back end works, and the result register holds one finished beat until
// it is popped. Registers on csr_ are written whenever csr_valid is high
// (csr_ready stays high) and are meant to change only while no beat is in flight.
module gyro_angle_integrator_with_calibration_top #(
   parameter int MAX_BATCH = 63
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_push,
   input  gaic_pkg::req_type                         req_data,
   output logic                                      req_full,
   output logic                                      rsp_empty,
   input  logic                                      rsp_pop,
   output gaic_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [gaic_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [gaic_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   gaic_pkg::cfg_type     cfg_ff;
   logic                  cmd_valid;
   gaic_pkg::cmd_type     cmd;
   logic                  cmd_pop;
   gaic_pkg::div_req_type div_req;
   gaic_pkg::div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_turn         <= gaic_pkg::HALF_TURN_RST;
         cfg_ff.stability_limit   <= gaic_pkg::STAB_LIMIT_RST;
         cfg_ff.calibration_count <= gaic_pkg::CAL_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gaic_pkg::CSR_HALF_TURN:  cfg_ff.half_turn         <= csr_wdata[29:0];
            gaic_pkg::CSR_STAB_LIMIT: cfg_ff.stability_limit   <= csr_wdata[15:0];
            gaic_pkg::CSR_CAL_COUNT:  cfg_ff.calibration_count <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   gaic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   gaic_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gaic_back #(
      .MAX_BATCH (MAX_BATCH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/gaic_front.sv]
// front end: accepts beats, classifies the mode and queues commands
module gaic_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  gaic_pkg::req_type   req_data,
   output logic                req_full,
   output logic                cmd_valid,
   output gaic_pkg::cmd_type   cmd,
   input  logic                cmd_pop
);

   localparam int PTR_W = $clog2(gaic_pkg::CMDQ_DEPTH);
   localparam int CNT_W = $clog2(gaic_pkg::CMDQ_DEPTH + 1);

   gaic_pkg::cmd_type q_ff [gaic_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   gaic_pkg::cmd_type new_cmd;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      new_cmd.sample = req_data.sample;
      new_cmd.last   = req_data.last_of_batch;
      unique case (req_data.mode)
         gaic_pkg::MODE_SAMPLE: new_cmd.op = gaic_pkg::OP_SAMPLE;
         gaic_pkg::MODE_START:  new_cmd.op = gaic_pkg::OP_START;
         gaic_pkg::MODE_ABORT:  new_cmd.op = gaic_pkg::OP_ABORT;
         default:               new_cmd.op = gaic_pkg::OP_NONE;
      endcase
   end

   assign req_full  = (cnt_ff == CNT_W'(gaic_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(gaic_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(gaic_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

[rtl/gaic_div.sv]
// serial restoring divider, one quotient bit per cycle
module gaic_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gaic_pkg::div_req_type div_req,
   output gaic_pkg::div_rsp_type div_rsp
);

   localparam int DW    = gaic_pkg::DIV_W;
   localparam int SW    = gaic_pkg::DSR_W;
   localparam int CNT_W = $clog2(DW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [SW-1:0]    dsr_ff;
   logic [SW:0]      shifted;
   logic [SW:0]      diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (shifted >= {1'b0, dsr_ff}) begin
         rem_in = diff[SW-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b1};
      end else begin
         rem_in = shifted[SW-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b0};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

[rtl/gaic_back.sv]
// back end: batch sums, angle wrap, calibration and result register
module gaic_back #(
   parameter int MAX_BATCH = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gaic_pkg::cfg_type     cfg,
   input  logic                  cmd_valid,
   input  gaic_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   output gaic_pkg::div_req_type div_req,
   input  gaic_pkg::div_rsp_type div_rsp,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output gaic_pkg::rsp_type     rsp_data
);

   localparam int SW = gaic_pkg::SAMPLE_W;
   localparam int BW = gaic_pkg::SUM_W;
   localparam int LW = gaic_pkg::LEN_W;
   localparam int AW = gaic_pkg::ANGLE_W;
   localparam int TW = gaic_pkg::TOTAL_W;
   localparam int DW = gaic_pkg::DIV_W;
   localparam int XW = AW + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RATE = 2'd1;
   localparam logic [1:0] ST_OFS  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic signed [SW-1:0] offset_ff, offset_in;
   logic signed [AW-1:0] angle_ff, angle_in;
   logic signed [BW-1:0] sum_ff, sum_in;
   logic [LW-1:0]        len_ff, len_in;
   logic signed [SW-1:0] mean_ff, mean_in;
   logic                 cal_active_ff, cal_active_in;
   logic [7:0]           seen_ff, seen_in;
   logic signed [SW-1:0] high_ff, high_in;
   logic signed [SW-1:0] low_ff, low_in;
   logic signed [TW-1:0] total_ff, total_in;
   logic                 neg_ff, neg_in;
   logic                 done_pend_ff, done_pend_in;
   logic                 new_data_ff, new_data_in;
   logic                 done_ff, done_in;
   logic                 out_valid_ff, out_valid_in;
   gaic_pkg::rsp_type    out_ff;
   logic                 out_load;

   logic signed [SW-1:0] corr;
   logic signed [BW-1:0] sum_new;
   logic [LW-1:0]        len_new;
   logic [BW-1:0]        sum_mag;
   logic signed [XW-1:0] acc_x;
   logic signed [XW-1:0] ht_x;
   logic signed [XW-1:0] ht2_x;
   logic signed [XW-1:0] wrap_x;
   logic signed [SW-1:0] hi_new;
   logic signed [SW-1:0] lo_new;
   logic signed [SW:0]   spread;
   logic [7:0]           seen_new;
   logic [7:0]           cnt;
   logic signed [DW-1:0] ofs_num;
   logic [DW-1:0]        ofs_mag;
   logic [SW-1:0]        q_lo;
   logic signed [SW-1:0] q_signed;

   always_comb begin
      corr    = cmd.sample - offset_ff;
      sum_new = sum_ff + BW'(corr);
      len_new = len_ff + 1'b1;
      sum_mag = sum_new[BW-1] ? BW'(-sum_new) : sum_new;
      acc_x   = XW'(angle_ff) + XW'(sum_new);
      ht_x    = $signed(XW'(cfg.half_turn));
      ht2_x   = $signed(XW'({cfg.half_turn, 1'b0}));
      if (acc_x >= ht_x) begin
         wrap_x = acc_x - ht2_x;
      end else if (acc_x < -ht_x) begin
         wrap_x = acc_x + ht2_x;
      end else begin
         wrap_x = acc_x;
      end
      hi_new   = (corr > high_ff) ? corr : high_ff;
      lo_new   = (corr < low_ff) ? corr : low_ff;
      spread   = (SW+1)'(hi_new) - (SW+1)'(lo_new);
      seen_new = seen_ff + 1'b1;
      cnt      = (cfg.calibration_count == '0) ? 8'd1 : cfg.calibration_count;
      ofs_num  = DW'(total_ff) + $signed(DW'(cnt[7:1]));
      ofs_mag  = ofs_num[DW-1] ? DW'(-ofs_num) : ofs_num;
      q_lo     = div_rsp.quot[SW-1:0];
      q_signed = neg_ff ? $signed(-q_lo) : $signed(q_lo);
   end

   always_comb begin
      state_in      = state_ff;
      offset_in     = offset_ff;
      angle_in      = angle_ff;
      sum_in        = sum_ff;
      len_in        = len_ff;
      mean_in       = mean_ff;
      cal_active_in = cal_active_ff;
      seen_in       = seen_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      total_in      = total_ff;
      neg_in        = neg_ff;
      done_pend_in  = done_pend_ff;
      new_data_in   = new_data_ff;
      done_in       = done_ff;
      cmd_pop       = 1'b0;
      out_load      = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DW'(sum_mag);
      div_req.divisor  = len_new;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               new_data_in  = 1'b0;
               done_in      = 1'b0;
               done_pend_in = 1'b0;
               state_in     = ST_EMIT;
               unique case (cmd.op)
                  gaic_pkg::OP_START: begin
                     offset_in     = '0;
                     cal_active_in = 1'b1;
                     seen_in       = '0;
                     high_in       = gaic_pkg::CAL_HIGH_RST;
                     low_in        = gaic_pkg::CAL_LOW_RST;
                     total_in      = '0;
                     sum_in        = '0;
                     len_in        = '0;
                  end
                  gaic_pkg::OP_ABORT: begin
                     sum_in = '0;
                     len_in = '0;
                  end
                  gaic_pkg::OP_SAMPLE: begin
                     if (cmd.last || len_new >= LW'(MAX_BATCH)) begin
                        angle_in      = wrap_x[AW-1:0];
                        sum_in        = '0;
                        len_in        = '0;
                        new_data_in   = 1'b1;
                        neg_in        = sum_new[BW-1];
                        div_req.start = 1'b1;
                        state_in      = ST_RATE;
                        if (cal_active_ff) begin
                           if (spread > $signed((SW+1)'(cfg.stability_limit))) begin
                              seen_in  = '0;
                              high_in  = gaic_pkg::CAL_HIGH_RST;
                              low_in   = gaic_pkg::CAL_LOW_RST;
                              total_in = '0;
                           end else begin
                              total_in = total_ff + TW'(corr);
                              if (seen_new >= cnt) begin
                                 angle_in      = '0;
                                 cal_active_in = 1'b0;
                                 done_in       = 1'b1;
                                 done_pend_in  = 1'b1;
                                 seen_in       = '0;
                                 high_in       = gaic_pkg::CAL_HIGH_RST;
                                 low_in        = gaic_pkg::CAL_LOW_RST;
                              end else begin
                                 seen_in = seen_new;
                                 high_in = hi_new;
                                 low_in  = lo_new;
                              end
                           end
                        end
                     end else begin
                        sum_in = sum_new;
                        len_in = len_new;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RATE: begin
            if (div_rsp.done) begin
               mean_in = q_signed;
               if (done_pend_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = ofs_mag;
                  div_req.divisor  = cnt;
                  neg_in           = ofs_num[DW-1];
                  total_in         = '0;
                  state_in         = ST_OFS;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_OFS: begin
            if (div_rsp.done) begin
               offset_in = q_signed;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         offset_ff     <= '0;
         angle_ff      <= '0;
         sum_ff        <= '0;
         len_ff        <= '0;
         mean_ff       <= '0;
         cal_active_ff <= 1'b0;
         seen_ff       <= '0;
         high_ff       <= gaic_pkg::CAL_HIGH_RST;
         low_ff        <= gaic_pkg::CAL_LOW_RST;
         total_ff      <= '0;
         neg_ff        <= 1'b0;
         done_pend_ff  <= 1'b0;
         new_data_ff   <= 1'b0;
         done_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         offset_ff     <= offset_in;
         angle_ff      <= angle_in;
         sum_ff        <= sum_in;
         len_ff        <= len_in;
         mean_ff       <= mean_in;
         cal_active_ff <= cal_active_in;
         seen_ff       <= seen_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         total_ff      <= total_in;
         neg_ff        <= neg_in;
         done_pend_ff  <= done_pend_in;
         new_data_ff   <= new_data_in;
         done_ff       <= done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff.angle            <= angle_ff[30:0];
         out_ff.rate             <= mean_ff;
         out_ff.new_data         <= new_data_ff;
         out_ff.calibrating      <= cal_active_ff;
         out_ff.calibration_done <= done_ff;
         out_ff.zero_offset      <= offset_ff;
      end
   end

endmodule

[rtl/gaic_checker.sv]
// port level checks of the gyro angle integrator and their bind
module gaic_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_push,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input gaic_pkg::rsp_type                 rsp_data
);

   // nothing queued or waiting right after reset
   a_reset_clear: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting result beat holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result beat changed before pop");

   // the command queue only fills on an accepted beat
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("input went full without a push");

   // finishing calibration ends a batch and clears the angle
   a_cal_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.calibration_done) |->
         (rsp_data.new_data && !rsp_data.calibrating && rsp_data.angle == '0))
      else $error("calibration done beat inconsistent");

endmodule

bind gyro_angle_integrator_with_calibration_top gaic_checker u_gaic_checker (.*);

[dv/tb_gyro_angle_integrator_with_calibration_top.sv]
// testbench for the gyro angle integrator: queue-side stimulus checked against a bit-true predictor
module tb_gyro_angle_integrator_with_calibration_top;

   localparam int MAX_BATCH = 63;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 80;
   localparam int SHOWN_MISMATCHES = 10;
   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam logic [7:0] DIRECTED_CAL_COUNT = 8'd4;

   typedef struct {
      logic [1:0]         mode;
      logic signed [15:0] sample;
      logic               last;
      int                 reps;
      bit                 typed;
      gaic_pkg::rsp_type  want;
   } row_type;

   typedef struct {
      logic [29:0] half_turn;
      logic [15:0] stab_limit;
      logic [7:0]  cal_count;
      int          send_pct;
      int          recv_pct;
      int          items;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   gaic_pkg::req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   gaic_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gaic_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gaic_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [29:0]        cfg_half_turn;
   logic [15:0]        cfg_stab_limit;
   logic [7:0]         cfg_cal_count;
   logic signed [15:0] zero_off;
   logic signed [15:0] last_corr;
   logic signed [31:0] angle_sum;
   logic signed [23:0] batch_acc;
   logic [7:0]         batch_cnt;
   logic signed [15:0] rate_mean;
   logic               cal_on;
   logic [7:0]         cal_batches;
   logic signed [15:0] cal_max;
   logic signed [15:0] cal_min;
   int                 cal_sum;

   gaic_pkg::rsp_type due_reports[$];
   gaic_pkg::req_type stim_q[$];
   int mismatches = 0;
   int send_pct = 0;
   int recv_pct = 0;
   int cycles = 0;

   row_type dir_rows [24] = '{
      '{MODE_IGNORED, 16'sh5a5a, 1'b1, 1, 1'b1,
        '{31'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0}},
      '{gaic_pkg::MODE_SAMPLE, 16'sd0, 1'b1, 1, 1'b1,
        '{31'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 16'sd0}},
      '{gaic_pkg::MODE_SAMPLE, 16'sh7fff, 1'b1, 1, 1'b1,
        '{31'sd32767, 16'sh7fff, 1'b1, 1'b0, 1'b0, 16'sd0}},
      '{gaic_pkg::MODE_SAMPLE, 16'sh8000, 1'b1, 1, 1'b1,
        '{-31'sd1, 16'sh8000, 1'b1, 1'b0, 1'b0, 16'sd0}},
      '{gaic_pkg::MODE_SAMPLE, 16'sd100, 1'b0, 1, 1'b1,
        '{-31'sd1, 16'sh8000, 1'b0, 1'b0, 1'b0, 16'sd0}},
      '{gaic_pkg::MODE_ABORT, 16'sd5, 1'b1, 1, 1'b1,
        '{-31'sd1, 16'sh8000, 1'b0, 1'b0, 1'b0, 16'sd0}},
      '{gaic_pkg::MODE_SAMPLE, 16'sd7, 1'b0, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, -16'sd2, 1'b1, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, -16'sd3, 1'b0, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, -16'sd4, 1'b1, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sh7fff, 1'b0, 63, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sh8000, 1'b0, 64, 1'b0, '0},
      '{gaic_pkg::MODE_ABORT, 16'sd0, 1'b0, 1, 1'b0, '0},
      '{gaic_pkg::MODE_START, -16'sd1, 1'b1, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sd40, 1'b1, 2, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sd500, 1'b1, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sd20, 1'b0, 2, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sd61, 1'b1, 4, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sd61, 1'b1, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, 16'sh8000, 1'b1, 1, 1'b0, '0},
      '{gaic_pkg::MODE_START, 16'sd9, 1'b0, 1, 1'b0, '0},
      '{gaic_pkg::MODE_SAMPLE, -16'sd7, 1'b1, 4, 1'b0, '0},
      '{MODE_IGNORED, 16'shffff, 1'b0, 1, 1'b0, '0},
      '{gaic_pkg::MODE_ABORT, 16'sh7fff, 1'b1, 1, 1'b0, '0}
   };

   phase_type phases [8] = '{
      '{gaic_pkg::HALF_TURN_RST, gaic_pkg::STAB_LIMIT_RST, gaic_pkg::CAL_COUNT_RST,
        0, 0, 300},
      '{30'd1, 16'd65535, 8'd1, 75, 0, 200},
      '{30'h3fffffff, 16'd0, 8'd255, 0, 75, 350},
      '{30'd1000, 16'd300, 8'd3, 11, 11, 200},
      '{30'd50000, 16'd2000, 8'd0, 0, 0, 200},
      '{30'd30000, 16'd40, 8'd6, 75, 0, 200},
      '{30'h3fffffff, 16'd65535, 8'd16, 0, 75, 200},
      '{30'd1, 16'd0, 8'd2, 11, 11, 150}
   };

   gyro_angle_integrator_with_calibration_top #(
      .MAX_BATCH(MAX_BATCH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_calibration();
      cal_batches = '0;
      cal_max = gaic_pkg::CAL_HIGH_RST;
      cal_min = gaic_pkg::CAL_LOW_RST;
      cal_sum = 0;
   endfunction

   function automatic void reset_integrator();
      cfg_half_turn = gaic_pkg::HALF_TURN_RST;
      cfg_stab_limit = gaic_pkg::STAB_LIMIT_RST;
      cfg_cal_count = gaic_pkg::CAL_COUNT_RST;
      zero_off = '0;
      last_corr = '0;
      angle_sum = '0;
      batch_acc = '0;
      batch_cnt = '0;
      rate_mean = '0;
      cal_on = 1'b0;
      clear_calibration();
   endfunction

   function automatic gaic_pkg::rsp_type integrate_item(input gaic_pkg::req_type d);
      logic signed [15:0] corr;
      longint ht;
      longint a;
      longint q;
      longint n;
      int cnt;
      logic fresh;
      logic finished;
      gaic_pkg::rsp_type r;
      fresh = 1'b0;
      finished = 1'b0;
      case (d.mode)
         gaic_pkg::MODE_START: begin
            zero_off = '0;
            cal_on = 1'b1;
            clear_calibration();
            batch_acc = '0;
            batch_cnt = '0;
         end
         gaic_pkg::MODE_ABORT: begin
            batch_acc = '0;
            batch_cnt = '0;
         end
         gaic_pkg::MODE_SAMPLE: begin
            corr = d.sample - zero_off;
            last_corr = corr;
            batch_acc = batch_acc + corr;
            batch_cnt = batch_cnt + 8'd1;
            if (d.last_of_batch || batch_cnt >= MAX_BATCH || batch_cnt == 8'd0) begin
               ht = longint'(cfg_half_turn);
               a = longint'(angle_sum) + longint'(batch_acc);
               n = (batch_cnt == 8'd0) ? 256 : longint'(batch_cnt);
               if (a >= ht) begin
                  a = a - 2 * ht;
               end else if (a < -ht) begin
                  a = a + 2 * ht;
               end
               angle_sum = a[31:0];
               q = longint'(batch_acc) / n;
               rate_mean = q[15:0];
               batch_acc = '0;
               batch_cnt = '0;
               fresh = 1'b1;
               if (cal_on) begin
                  if (last_corr > cal_max) cal_max = last_corr;
                  if (last_corr < cal_min) cal_min = last_corr;
                  if (longint'(cal_max) - longint'(cal_min) > longint'(cfg_stab_limit)) begin
                     clear_calibration();
                  end else begin
                     cnt = (cfg_cal_count == 8'd0) ? 1 : int'(cfg_cal_count);
                     cal_batches = cal_batches + 8'd1;
                     cal_sum = cal_sum + int'(last_corr);
                     if (cal_batches >= cnt) begin
                        q = (longint'(cal_sum) + longint'(cnt / 2)) / longint'(cnt);
                        zero_off = q[15:0];
                        angle_sum = '0;
                        cal_on = 1'b0;
                        finished = 1'b1;
                        clear_calibration();
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.angle = angle_sum[30:0];
      r.rate = rate_mean;
      r.new_data = fresh;
      r.calibrating = cal_on;
      r.calibration_done = finished;
      r.zero_offset = zero_off;
      return r;
   endfunction

   function automatic string show(input gaic_pkg::rsp_type r);
      return $sformatf("angle=%0d rate=%0d new=%0b cal=%0b done=%0b offset=%0d",
                       r.angle, r.rate, r.new_data, r.calibrating, r.calibration_done,
                       r.zero_offset);
   endfunction

   function automatic void check_report(input gaic_pkg::rsp_type got);
      gaic_pkg::rsp_type want;
      if (due_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES)
            $display("unexpected beat: %s", show(got));
      end else begin
         want = due_reports.pop_front();
         if (got.angle !== want.angle || got.rate !== want.rate ||
             got.new_data !== want.new_data || got.calibrating !== want.calibrating ||
             got.calibration_done !== want.calibration_done ||
             got.zero_offset !== want.zero_offset) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
               $display("mismatch\n  want %s\n  got  %s", show(want), show(got));
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_report(rsp_data);
         rsp_pop <= ($urandom_range(0, 99) >= recv_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic drive_item(input gaic_pkg::req_type d, input bit typed,
                             input gaic_pkg::rsp_type want);
      gaic_pkg::rsp_type got;
      while ($urandom_range(0, 99) < send_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_full) @(posedge clock);
      got = integrate_item(d);
      due_reports.push_back(typed ? want : got);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [29:0] ht, input logic [15:0] stab,
                                input logic [7:0] cnt);
      logic [gaic_pkg::CSR_DATA_W-1:0] vals [3];
      logic [gaic_pkg::CSR_IDX_W-1:0] idxs [3];
      vals[0] = ht;
      vals[1] = gaic_pkg::CSR_DATA_W'(stab);
      vals[2] = gaic_pkg::CSR_DATA_W'(cnt);
      idxs[0] = gaic_pkg::CSR_HALF_TURN;
      idxs[1] = gaic_pkg::CSR_STAB_LIMIT;
      idxs[2] = gaic_pkg::CSR_CAL_COUNT;
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg_half_turn = ht;
      cfg_stab_limit = stab;
      cfg_cal_count = cnt;
   endtask

   function automatic logic signed [15:0] pick_sample();
      logic [15:0] v;
      case ($urandom_range(0, 19))
         0: v = 16'h7fff;
         1: v = 16'h8000;
         2: v = 16'h0000;
         3: v = 16'hffff;
         default: v = 16'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   task automatic queue_sequence();
      int r;
      int base;
      int spread;
      int nb;
      int len;
      int v;
      bit long_run;
      gaic_pkg::req_type it;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         // calibration run with steady last readings
         base = $urandom_range(0, 60000) - 30000;
         spread = (cfg_stab_limit > 16'd2700) ? 2700 : int'(cfg_stab_limit);
         it.mode = gaic_pkg::MODE_START;
         it.sample = pick_sample();
         it.last_of_batch = 1'($urandom_range(0, 1));
         stim_q.push_back(it);
         nb = ((cfg_cal_count == 8'd0) ? 1 : int'(cfg_cal_count)) + $urandom_range(0, 2);
         for (int b = 0; b < nb; b++) begin
            if ($urandom_range(0, 49) == 0) begin
               it.mode = ($urandom_range(0, 1) == 0) ? gaic_pkg::MODE_ABORT : MODE_IGNORED;
               it.sample = pick_sample();
               it.last_of_batch = 1'($urandom_range(0, 1));
               stim_q.push_back(it);
            end
            len = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
            for (int s = 1; s <= len; s++) begin
               it.mode = gaic_pkg::MODE_SAMPLE;
               it.last_of_batch = (s == len);
               if (s == len) begin
                  v = base + $urandom_range(0, spread);
                  if ($urandom_range(0, 199) == 0) v = v + 2000;
                  it.sample = v[15:0];
               end else begin
                  it.sample = pick_sample();
               end
               stim_q.push_back(it);
            end
         end
      end else if (r < 85) begin
         nb = $urandom_range(1, 6);
         for (int b = 0; b < nb; b++) begin
            long_run = ($urandom_range(0, 19) == 0);
            len = long_run ? $urandom_range(60, 66) : $urandom_range(1, 8);
            for (int s = 1; s <= len; s++) begin
               it.mode = gaic_pkg::MODE_SAMPLE;
               it.sample = pick_sample();
               it.last_of_batch = !long_run && (s == len);
               stim_q.push_back(it);
            end
         end
      end else begin
         nb = $urandom_range(1, 5);
         for (int k = 0; k < nb; k++) begin
            it.mode = 2'($urandom_range(0, 3));
            it.sample = pick_sample();
            it.last_of_batch = 1'($urandom_range(0, 1));
            stim_q.push_back(it);
         end
      end
   endtask

   initial begin
      gaic_pkg::req_type d;
      int sent;
      reset_integrator();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      load_settings(gaic_pkg::HALF_TURN_RST, gaic_pkg::STAB_LIMIT_RST, DIRECTED_CAL_COUNT);

      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++) begin
            d.mode = dir_rows[i].mode;
            d.sample = dir_rows[i].sample;
            d.last_of_batch = dir_rows[i].last;
            drive_item(d, dir_rows[i].typed && (k == dir_rows[i].reps - 1),
                       dir_rows[i].want);
         end
      end
      drain();

      foreach (phases[p]) begin
         load_settings(phases[p].half_turn, phases[p].stab_limit, phases[p].cal_count);
         send_pct = phases[p].send_pct;
         recv_pct = phases[p].recv_pct;
         sent = 0;
         while (sent < phases[p].items) begin
            queue_sequence();
            while (stim_q.size() != 0 && sent < phases[p].items) begin
               drive_item(stim_q.pop_front(), 1'b0, '0);
               sent++;
            end
            stim_q.delete();
            if ($urandom_range(0, 39) == 0) drain();
         end
      end

      req_push <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[gyro_angle_integrator_with_calibration_top.f]
rtl/gaic_pkg.sv
rtl/gaic_front.sv
rtl/gaic_div.sv
rtl/gaic_back.sv
rtl/gyro_angle_integrator_with_calibration_top.sv
rtl/gaic_checker.sv
dv/tb_gyro_angle_integrator_with_calibration_top.sv
